>>> src/sha1h_pkg.sv
// sha1h_pkg: shared types, constants and round functions of the SHA-1 hasher.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
`default_nettype none

package sha1h_pkg;

    // Command codes on the request channel
    localparam logic [1:0] CMD_ABSORB  = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // Standard initial chaining values
    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    // Round constants
    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd56;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_PADLEN,
        ST_LOADW,
        ST_ROUND,
        ST_ADD,
        ST_RESP
    } sha1h_state_t;

    // Source of the byte shifted into the block window
    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN
    } sha1h_byte_sel_t;

    typedef struct packed {
        logic            shift_en;
        sha1h_byte_sel_t byte_sel;
        logic            count_en;
        logic            set_broken;
        logic            set_finished;
        logic            restart;
        logic            load_work;
        logic            round_en;
        logic            add_chain;
        logic            load_out;
    } sha1h_cmd_t;

    typedef struct packed {
        logic block_full;
        logic at_len;
        logic finished;
        logic broken;
        logic round_last;
        logic out_free;
    } sha1h_status_t;

    function automatic logic [31:0] sha1h_f(input logic [6:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] res;
        if (rnd < 7'd20)
        begin
            res = (b & c) | (~b & d);
        end
        else if (rnd < 7'd40)
        begin
            res = b ^ c ^ d;
        end
        else if (rnd < 7'd60)
        begin
            res = (b & c) | (b & d) | (c & d);
        end
        else
        begin
            res = b ^ c ^ d;
        end
        return res;
    endfunction

    function automatic logic [31:0] sha1h_k(input logic [6:0] rnd);
        logic [31:0] res;
        if (rnd < 7'd20)
        begin
            res = K_R0;
        end
        else if (rnd < 7'd40)
        begin
            res = K_R1;
        end
        else if (rnd < 7'd60)
        begin
            res = K_R2;
        end
        else
        begin
            res = K_R3;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/sha1h_if.sv
// sha1h_if: valid/ready channel interfaces for the hasher's request and response words.
// Depends on nothing; field widths are fixed.
`default_nettype none

interface sha1h_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface sha1h_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
    logic [31:0] digest_e;
    logic        ok;

    modport source (output valid, output digest_a, output digest_b, output digest_c,
                    output digest_d, output digest_e, output ok, input ready);
    modport sink   (input valid, input digest_a, input digest_b, input digest_c,
                    input digest_d, input digest_e, input ok, output ready);
endinterface

`default_nettype wire

>>> src/sha1h_ctrl.sv
// sha1h_ctrl: sequencing state machine of the SHA-1 hasher.
// Depends on sha1h_pkg; drives sha1h_datapath through sha1h_cmd_t.
`default_nettype none

module sha1h_ctrl
    import sha1h_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [1:0]    in_cmd,
    output logic               in_ready,
    input  wire sha1h_status_t status,
    output sha1h_cmd_t         cmd
);

    sha1h_state_t state_reg, state_next;
    logic         fin_reg, fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_cmd)
                        CMD_ABSORB:
                        begin
                            if (!status.finished && !status.broken && status.block_full)
                                state_next = ST_LOADW;
                        end
                        CMD_READ:
                        begin
                            if (status.broken || status.finished)
                            begin
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_PAD80;
                                fin_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PAD80:
            begin
                state_next = status.block_full ? ST_LOADW : ST_PADZ;
            end
            ST_PADZ:
            begin
                if (status.at_len)
                    state_next = ST_PADLEN;
                else if (status.block_full)
                    state_next = ST_LOADW;
            end
            ST_PADLEN:
            begin
                if (status.block_full)
                    state_next = ST_LOADW;
            end
            ST_LOADW:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (status.round_last)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (status.finished)
                    state_next = ST_RESP;
                else if (fin_reg)
                    state_next = ST_PADZ;
                else
                    state_next = ST_IDLE;
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                    fin_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        cmd      = '0;
        cmd.byte_sel = SEL_DATA;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_cmd)
                        CMD_ABSORB:
                        begin
                            if (status.finished || status.broken)
                            begin
                                cmd.set_broken = 1'b1;
                            end
                            else
                            begin
                                cmd.shift_en = 1'b1;
                                cmd.count_en = 1'b1;
                            end
                        end
                        CMD_RESTART:
                        begin
                            cmd.restart = 1'b1;
                        end
                        default:
                        begin
                            cmd.shift_en = 1'b0;
                        end
                    endcase
                end
            end
            ST_PAD80:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = SEL_PAD;
            end
            ST_PADZ:
            begin
                cmd.shift_en = !status.at_len;
                cmd.byte_sel = SEL_ZERO;
            end
            ST_PADLEN:
            begin
                cmd.shift_en     = 1'b1;
                cmd.byte_sel     = SEL_LEN;
                cmd.set_finished = status.block_full;
            end
            ST_LOADW:
            begin
                cmd.load_work = 1'b1;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
            end
            ST_ADD:
            begin
                cmd.add_chain = 1'b1;
            end
            ST_RESP:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd.shift_en = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/sha1h_datapath.sv
// sha1h_datapath: block window, message schedule, round unit, chaining words and
// response register of the SHA-1 hasher. Depends on sha1h_pkg.
`default_nettype none

module sha1h_datapath
    import sha1h_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire sha1h_cmd_t cmd,
    output sha1h_status_t   status,
    input  wire logic [7:0] data_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [31:0]     digest_a,
    output logic [31:0]     digest_b,
    output logic [31:0]     digest_c,
    output logic [31:0]     digest_d,
    output logic [31:0]     digest_e,
    output logic            ok
);

    // Block window: word 0 is the oldest, bytes enter at the bottom of word 15
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] chain_reg [5];
    logic [31:0] chain_next [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [6:0]  round_reg, round_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic        finished_reg, finished_next;
    logic        broken_reg, broken_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] dig_reg [5];
    logic [31:0] dig_next [5];
    logic        ok_reg, ok_next;

    logic [7:0]  in_byte;
    logic [7:0]  len_byte;
    logic [2:0]  len_idx;
    logic [31:0] sched_word;
    logic [31:0] round_sum;
    logic [63:0] bitlen_inc;

    assign len_idx    = ~fill_reg[2:0];
    assign len_byte   = bitlen_reg[{len_idx, 3'b000} +: 8];
    assign sched_word = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign round_sum  = {a_reg[26:0], a_reg[31:27]} + sha1h_f(round_reg, b_reg, c_reg, d_reg)
                      + e_reg + w_reg[0] + sha1h_k(round_reg);
    assign bitlen_inc = bitlen_reg + 64'd8;

    always_comb
    begin
        case (cmd.byte_sel)
            SEL_DATA: in_byte = data_byte;
            SEL_PAD:  in_byte = PAD_BYTE;
            SEL_LEN:  in_byte = len_byte;
            default:  in_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        w_next        = w_reg;
        chain_next    = chain_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        c_next        = c_reg;
        d_next        = d_reg;
        e_next        = e_reg;
        round_next    = round_reg;
        fill_next     = fill_reg;
        bitlen_next   = bitlen_reg;
        finished_next = finished_reg;
        broken_next   = broken_reg;
        dig_next      = dig_reg;
        ok_next       = ok_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.shift_en)
        begin
            for (int i = 0; i < 15; i++)
                w_next[i] = {w_reg[i][23:0], w_reg[i + 1][31:24]};
            w_next[15] = {w_reg[15][23:0], in_byte};
            fill_next  = fill_reg + 6'd1;
        end
        if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
                w_next[i] = w_reg[i + 1];
            w_next[15] = {sched_word[30:0], sched_word[31]};
            a_next     = round_sum;
            b_next     = a_reg;
            c_next     = {b_reg[1:0], b_reg[31:2]};
            d_next     = c_reg;
            e_next     = d_reg;
            round_next = round_reg + 7'd1;
        end
        if (cmd.count_en)
        begin
            bitlen_next = bitlen_inc;
            if (bitlen_inc == 64'd0)
                broken_next = 1'b1;
        end
        if (cmd.set_broken)
            broken_next = 1'b1;
        if (cmd.set_finished)
            finished_next = 1'b1;
        if (cmd.load_work)
        begin
            a_next     = chain_reg[0];
            b_next     = chain_reg[1];
            c_next     = chain_reg[2];
            d_next     = chain_reg[3];
            e_next     = chain_reg[4];
            round_next = '0;
        end
        if (cmd.add_chain)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end
        if (cmd.restart)
        begin
            chain_next[0] = H0_INIT;
            chain_next[1] = H1_INIT;
            chain_next[2] = H2_INIT;
            chain_next[3] = H3_INIT;
            chain_next[4] = H4_INIT;
            fill_next     = '0;
            bitlen_next   = '0;
            finished_next = 1'b0;
            broken_next   = 1'b0;
        end
        if (cmd.load_out)
        begin
            for (int i = 0; i < 5; i++)
                dig_next[i] = broken_reg ? 32'd0 : chain_reg[i];
            ok_next        = !broken_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0]  <= H0_INIT;
            chain_reg[1]  <= H1_INIT;
            chain_reg[2]  <= H2_INIT;
            chain_reg[3]  <= H3_INIT;
            chain_reg[4]  <= H4_INIT;
            fill_reg      <= '0;
            bitlen_reg    <= '0;
            finished_reg  <= 1'b0;
            broken_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            round_reg     <= '0;
        end
        else
        begin
            chain_reg     <= chain_next;
            fill_reg      <= fill_next;
            bitlen_reg    <= bitlen_next;
            finished_reg  <= finished_next;
            broken_reg    <= broken_next;
            out_valid_reg <= out_valid_next;
            round_reg     <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        dig_reg <= dig_next;
        ok_reg  <= ok_next;
    end

    assign status.block_full = (fill_reg == LAST_POS);
    assign status.at_len     = (fill_reg == LEN_POS);
    assign status.finished   = finished_reg;
    assign status.broken     = broken_reg;
    assign status.round_last = (round_reg == LAST_ROUND);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign digest_a  = dig_reg[0];
    assign digest_b  = dig_reg[1];
    assign digest_c  = dig_reg[2];
    assign digest_d  = dig_reg[3];
    assign digest_e  = dig_reg[4];
    assign ok        = ok_reg;

endmodule

`default_nettype wire

>>> src/sha1_byte_stream_hasher.sv
// SHA-1 byte-stream hasher. Each request word carries a command: absorb one message
// byte, read the digest, or restart. Bytes are absorbed one per cycle while the hasher
// is ready; the byte that completes a 64-byte block starts its compression (load, 80
// compression rounds at one round per cycle, chain update), during which no word is
// taken. The first read finalizes: padding bytes enter one per cycle (64 - n bytes
// when n bytes of the block are filled and n < 56, else 128 - n), with a pause in
// which no byte enters where the length field starts; each padded block (one or two)
// is compressed and the response register is loaded. Later reads give the same digest.
// A byte after finalization, or a wrap of the 64-bit bit count, sets a sticky error;
// reads then return ok = 0 with zero words until restart.
// Command code 3 is taken and ignored. Absorb and restart words keep flowing while a
// response waits in the output register; a read waits in the controller until the
// output register is free. Depends on sha1h_pkg, sha1h_if, sha1h_ctrl, sha1h_datapath.
`default_nettype none

module sha1_byte_stream_hasher
    import sha1h_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sha1h_req_if.sink  req,
    sha1h_rsp_if.source rsp
);

    sha1h_cmd_t    dp_cmd;
    sha1h_status_t dp_status;
    logic          req_ready;

    // Controller: decodes accepted words and sequences padding and compression
    sha1h_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_cmd   (req.cmd),
        .in_ready (req_ready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    assign req.ready = req_ready;

    // Datapath: block window, rounds, chaining words, response register
    sha1h_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .data_byte (req.data_byte),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .digest_a  (rsp.digest_a),
        .digest_b  (rsp.digest_b),
        .digest_c  (rsp.digest_c),
        .digest_d  (rsp.digest_d),
        .digest_e  (rsp.digest_e),
        .ok        (rsp.ok)
    );

endmodule

`default_nettype wire

>>> src/sha1h_checker.sv
// sha1h_checker: port-level assertions for sha1_byte_stream_hasher, with its bind.
// Depends on sha1h_pkg and the top level's ports.
`default_nettype none

module sha1h_checker
    import sha1h_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic [1:0]  req_cmd,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [31:0] digest_a,
    input wire logic [31:0] digest_b,
    input wire logic [31:0] digest_c,
    input wire logic [31:0] digest_d,
    input wire logic [31:0] digest_e,
    input wire logic        ok
);

    logic req_take;
    assign req_take = req_valid && req_ready;

    // Hold a stalled response word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(digest_a) && $stable(digest_e) && $stable(ok))
        else $error("response changed while stalled");

    // Error responses carry zero words
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !ok |-> digest_a == 32'd0 && digest_b == 32'd0 && digest_c == 32'd0
                             && digest_d == 32'd0 && digest_e == 32'd0)
        else $error("error response with nonzero digest");

    // Only a read produces a response
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        req_take && req_cmd != CMD_READ && !rsp_valid |=> !rsp_valid)
        else $error("response without a read");

    // A read occupies the block for at least the following cycle
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_take && req_cmd == CMD_READ |=> !req_ready)
        else $error("ready right after a read");

endmodule

bind sha1_byte_stream_hasher sha1h_checker u_sha1h_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_cmd   (req.cmd),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .digest_a  (rsp.digest_a),
    .digest_b  (rsp.digest_b),
    .digest_c  (rsp.digest_c),
    .digest_d  (rsp.digest_d),
    .digest_e  (rsp.digest_e),
    .ok        (rsp.ok)
);

`default_nettype wire
